// ===== sv/psev_pkg.sv =====
// psev_pkg: shared constants and types for the power series evaluator
// covers field widths, fixed-point defaults, series mode codes, register indexes, fsm states
// no dependencies
package psev_pkg;

    localparam int MAX_TERMS_DEF = 30;
    localparam int FRAC_BITS_DEF = 40;

    localparam int DATA_W  = 64;
    localparam int EPS_W   = 63;
    localparam int X_W     = 32;
    localparam int X_FRAC  = 24;
    localparam int SQ_FRAC = 48;
    localparam int OUT_N_W = 5;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = 128;
    localparam int CFG_IDX_W = 2;

    localparam logic [EPS_W-1:0] EPS_RESET = 63'd1099512;

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd1;

    typedef enum logic [1:0] {
        MODE_EXP,
        MODE_COS,
        MODE_C,
        MODE_D
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_WAIT,
        ST_CHECK,
        ST_RATIO_WAIT,
        ST_TERM_ISSUE,
        ST_TERM_WAIT,
        ST_ACCUM,
        ST_DONE
    } state_t;

endpackage

// ===== sv/power_series_evaluator.sv =====
// power_series_evaluator: term-recurrence series sum on one shared 32x32 multiplier
// the four-beat multiply is used twice per term; squaring x costs one multiply
// busy stays high from start through the done cycle; next start is taken in the cycle after done
// rst_n is asynchronous: control and config go to their reset values (epsilon 1099512, exp)
// the done strobe lasts one cycle and cannot be held off by the receiver
module power_series_evaluator #(
    parameter int MAX_TERMS = psev_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = psev_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [psev_pkg::X_W-1:0]            x_value,
    output logic                                done,
    output logic signed [psev_pkg::DATA_W-1:0]  sum_value,
    output logic                                overflow,
    output logic [psev_pkg::OUT_N_W-1:0]        terms_used,
    input  logic                                cfg_write,
    input  logic [psev_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psev_pkg::EPS_W-1:0]          cfg_data
);

    localparam int N_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W   = $clog2(MAX_TERMS);
    localparam int X_SHL   = (FRAC_BITS >= psev_pkg::X_FRAC) ? FRAC_BITS - psev_pkg::X_FRAC : 0;
    localparam int X_SHR   = (FRAC_BITS >= psev_pkg::X_FRAC) ? 0 : psev_pkg::X_FRAC - FRAC_BITS;
    localparam int SQ_SHR  = psev_pkg::SQ_FRAC - FRAC_BITS;
    localparam int SAT_LSB = FRAC_BITS + psev_pkg::DATA_W - 1;
    localparam logic [psev_pkg::DATA_W-1:0] MAG_MAX = {1'b0, {(psev_pkg::DATA_W-1){1'b1}}};
    localparam logic [psev_pkg::DATA_W-1:0] ONE_Q   = 64'(1) << FRAC_BITS;
    localparam logic [psev_pkg::DATA_W-1:0] INT_MIN = {1'b1, {(psev_pkg::DATA_W-1){1'b0}}};

    psev_pkg::state_t state_reg;
    psev_pkg::state_t state_next;
    psev_pkg::mode_t  mode_reg;
    logic [psev_pkg::EPS_W-1:0] eps_reg;

    logic [psev_pkg::DATA_W-1:0] f_reg;
    logic [psev_pkg::DATA_W-1:0] ratio_reg;
    logic [psev_pkg::DATA_W-1:0] tmag_reg;
    logic                        tsign_reg;
    logic [psev_pkg::DATA_W-1:0] sum_reg;
    logic [N_W-1:0]              n_reg;
    logic                        first_reg;
    logic                        ovf_reg;

    logic                        mul_start;
    logic [psev_pkg::DATA_W-1:0] mul_a;
    logic [psev_pkg::DATA_W-1:0] mul_b;
    logic                        mul_done;
    logic [psev_pkg::PROD_W-1:0] mul_product;
    logic [psev_pkg::DATA_W-1:0] coef;

    logic [psev_pkg::DATA_W-1:0] x_ext;
    logic [psev_pkg::DATA_W-1:0] x_scaled;
    logic                        prod_sat;
    logic [psev_pkg::DATA_W-1:0] prod_mag;
    logic [psev_pkg::DATA_W-1:0] eps_ext;
    logic                        mag_ok;
    logic                        go;
    logic                        neg_series;
    logic [psev_pkg::DATA_W-1:0] term_val;
    logic [psev_pkg::DATA_W:0]   sum_wide;
    logic                        sum_sat;
    logic [psev_pkg::DATA_W-1:0] sum_next;

    psev_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    psev_coef #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .mode (mode_reg),
        .idx  (n_reg[IDX_W-1:0]),
        .coef (coef)
    );

    assign x_ext    = 64'(x_value);
    assign x_scaled = (x_ext << X_SHL) >> X_SHR;

    // q-format truncation of the product, clamp magnitude to 2^63-1
    assign prod_sat = |mul_product[psev_pkg::PROD_W-1:SAT_LSB];
    assign prod_mag = prod_sat ? MAG_MAX : mul_product[SAT_LSB:FRAC_BITS];

    assign eps_ext = {1'b0, eps_reg};
    assign mag_ok  = (mode_reg == psev_pkg::MODE_EXP) ? (tmag_reg >= eps_ext)
                                                      : (tmag_reg > eps_ext);
    assign go = first_reg || (mag_ok && (n_reg < N_W'(MAX_TERMS)));

    assign neg_series = (mode_reg == psev_pkg::MODE_COS) || (mode_reg == psev_pkg::MODE_D);

    // saturating signed add of the signed term
    assign term_val = tsign_reg ? (~tmag_reg + 64'd1) : tmag_reg;
    assign sum_wide = {sum_reg[psev_pkg::DATA_W-1], sum_reg}
                    + {term_val[psev_pkg::DATA_W-1], term_val};
    assign sum_sat  = sum_wide[psev_pkg::DATA_W] != sum_wide[psev_pkg::DATA_W-1];
    assign sum_next = !sum_sat ? sum_wide[psev_pkg::DATA_W-1:0]
                    : (sum_wide[psev_pkg::DATA_W] ? INT_MIN : MAG_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psev_pkg::ST_IDLE;
            eps_reg   <= psev_pkg::EPS_RESET;
            mode_reg  <= psev_pkg::MODE_EXP;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == psev_pkg::REG_EPSILON)
                begin
                    eps_reg <= cfg_data;
                end
                else if (cfg_index == psev_pkg::REG_MODE)
                begin
                    mode_reg <= psev_pkg::mode_t'(cfg_data[1:0]);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psev_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (mode_reg == psev_pkg::MODE_EXP) ? psev_pkg::ST_CHECK
                                                                  : psev_pkg::ST_SQ_WAIT;
                end
            end
            psev_pkg::ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = psev_pkg::ST_CHECK;
                end
            end
            psev_pkg::ST_CHECK:
            begin
                state_next = go ? psev_pkg::ST_RATIO_WAIT : psev_pkg::ST_DONE;
            end
            psev_pkg::ST_RATIO_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = psev_pkg::ST_TERM_ISSUE;
                end
            end
            psev_pkg::ST_TERM_ISSUE:
            begin
                state_next = psev_pkg::ST_TERM_WAIT;
            end
            psev_pkg::ST_TERM_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = psev_pkg::ST_ACCUM;
                end
            end
            psev_pkg::ST_ACCUM:
            begin
                state_next = psev_pkg::ST_CHECK;
            end
            psev_pkg::ST_DONE:
            begin
                state_next = psev_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = state_reg != psev_pkg::ST_IDLE;
        done      = state_reg == psev_pkg::ST_DONE;
        mul_start = 1'b0;
        mul_a     = f_reg;
        mul_b     = coef;
        unique case (state_reg)
            psev_pkg::ST_IDLE:
            begin
                // x*x for every mode but exp
                mul_start = start && (mode_reg != psev_pkg::MODE_EXP);
                mul_a     = x_ext;
                mul_b     = x_ext;
            end
            psev_pkg::ST_CHECK:
            begin
                mul_start = go;
            end
            psev_pkg::ST_TERM_ISSUE:
            begin
                mul_start = 1'b1;
                mul_a     = tmag_reg;
                mul_b     = ratio_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == psev_pkg::ST_IDLE && start)
        begin
            f_reg     <= x_scaled;
            tmag_reg  <= ONE_Q;
            tsign_reg <= 1'b0;
            sum_reg   <= (mode_reg == psev_pkg::MODE_D) ? '0 : ONE_Q;
            n_reg     <= N_W'(1);
            first_reg <= mode_reg == psev_pkg::MODE_D;
            ovf_reg   <= 1'b0;
        end
        if (state_reg == psev_pkg::ST_SQ_WAIT && mul_done)
        begin
            f_reg <= mul_product[psev_pkg::DATA_W-1:0] >> SQ_SHR;
        end
        if (state_reg == psev_pkg::ST_RATIO_WAIT && mul_done)
        begin
            ratio_reg <= prod_mag;
            ovf_reg   <= ovf_reg | prod_sat;
        end
        if (state_reg == psev_pkg::ST_TERM_WAIT && mul_done)
        begin
            tmag_reg  <= prod_mag;
            tsign_reg <= tsign_reg ^ neg_series;
            ovf_reg   <= ovf_reg | prod_sat;
        end
        if (state_reg == psev_pkg::ST_ACCUM)
        begin
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_reg | sum_sat;
            n_reg     <= n_reg + N_W'(1);
            first_reg <= 1'b0;
        end
    end

    assign sum_value  = sum_reg;
    assign overflow   = ovf_reg;
    assign terms_used = psev_pkg::OUT_N_W'(n_reg);

endmodule

// ===== sv/psev_mul.sv =====
// psev_mul: 64x64 unsigned multiplier built on one 32x32 multiplier over four beats
// returns the exact 128-bit product, done pulses one cycle when it is ready
// depends on psev_pkg
module psev_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [psev_pkg::DATA_W-1:0]      a,
    input  logic [psev_pkg::DATA_W-1:0]      b,
    output logic                             done,
    output logic [psev_pkg::PROD_W-1:0]      product
);

    logic [psev_pkg::DATA_W-1:0] a_reg;
    logic [psev_pkg::DATA_W-1:0] b_reg;
    logic [psev_pkg::DATA_W-1:0] prod_reg;
    logic [1:0]                  sh_reg;
    logic [psev_pkg::PROD_W-1:0] acc_reg;
    logic [2:0]                  cnt_reg;
    logic                        active_reg;
    logic                        done_reg;

    logic [psev_pkg::HALF_W-1:0] ha;
    logic [psev_pkg::HALF_W-1:0] hb;
    logic [1:0]                  sh_sel;
    logic [psev_pkg::DATA_W-1:0] slice_prod;
    logic [psev_pkg::PROD_W-1:0] slice_shifted;

    // slices in order a0*b0, a0*b1, a1*b0, a1*b1; shift in units of 32 bits
    assign ha = cnt_reg[1] ? a_reg[psev_pkg::DATA_W-1:psev_pkg::HALF_W]
                           : a_reg[psev_pkg::HALF_W-1:0];
    assign hb = cnt_reg[0] ? b_reg[psev_pkg::DATA_W-1:psev_pkg::HALF_W]
                           : b_reg[psev_pkg::HALF_W-1:0];
    assign sh_sel = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
    assign slice_prod = ha * hb;
    assign slice_shifted = {{(psev_pkg::PROD_W-psev_pkg::DATA_W){1'b0}}, prod_reg}
                           << {sh_reg, 5'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= 3'd0;
            end
            else if (active_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // product register sits one beat ahead of the accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                prod_reg <= slice_prod;
                sh_reg   <= sh_sel;
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + slice_shifted;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/psev_coef.sv =====
// psev_coef: constant coefficient tables c(n), one per series mode
// entries are worked out at elaboration from MAX_TERMS and FRAC_BITS
// depends on psev_pkg
module psev_coef #(
    parameter int MAX_TERMS = psev_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = psev_pkg::FRAC_BITS_DEF
) (
    input  psev_pkg::mode_t                  mode,
    input  logic [$clog2(MAX_TERMS)-1:0]     idx,
    output logic [psev_pkg::DATA_W-1:0]      coef
);

    localparam logic [psev_pkg::PROD_W-1:0] ONE = 128'(1) << FRAC_BITS;

    logic [psev_pkg::DATA_W-1:0] tab_exp [MAX_TERMS];
    logic [psev_pkg::DATA_W-1:0] tab_cos [MAX_TERMS];
    logic [psev_pkg::DATA_W-1:0] tab_c   [MAX_TERMS];
    logic [psev_pkg::DATA_W-1:0] tab_d   [MAX_TERMS];

    // index zero is never read
    assign tab_exp[0] = '0;
    assign tab_cos[0] = '0;
    assign tab_c[0]   = '0;
    assign tab_d[0]   = '0;

    for (genvar g = 1; g < MAX_TERMS; g++)
    begin : g_tab
        localparam logic [psev_pkg::PROD_W-1:0] C_EXP = ONE / 128'(g);
        localparam logic [psev_pkg::PROD_W-1:0] C_COS = ONE / 128'(4 * g * g - 2 * g);
        localparam logic [psev_pkg::PROD_W-1:0] C_C =
            (128'(9 * g * g) << FRAC_BITS) / 128'((3 * g - 1) * (3 * g - 2));
        localparam logic [psev_pkg::PROD_W-1:0] C_D =
            (128'(2 * g - 1) << FRAC_BITS) / 128'(2 * g);
        assign tab_exp[g] = C_EXP[psev_pkg::DATA_W-1:0];
        assign tab_cos[g] = C_COS[psev_pkg::DATA_W-1:0];
        assign tab_c[g]   = C_C[psev_pkg::DATA_W-1:0];
        assign tab_d[g]   = C_D[psev_pkg::DATA_W-1:0];
    end

    always_comb
    begin
        unique case (mode)
            psev_pkg::MODE_EXP: coef = tab_exp[idx];
            psev_pkg::MODE_COS: coef = tab_cos[idx];
            psev_pkg::MODE_C:   coef = tab_c[idx];
            psev_pkg::MODE_D:   coef = tab_d[idx];
        endcase
    end

endmodule

// ===== sv/psev_checker.sv =====
// psev_checker: port-level checks of the start/busy/done command handshake
// bound to power_series_evaluator; no package dependency
module psev_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a beat taken must raise busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while not busy");

    // one-cycle strobe, block is free right after
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done strobe not followed by idle");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

bind power_series_evaluator psev_checker u_psev_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
